// File: rtl/lis_pkg.sv
`timescale 1ns / 1ps

package lis_pkg;

  // Table capacity, one cell per tail entry
  localparam int MAX_LEN    = 1024;
  // Width of one value
  localparam int DATA_WIDTH = 32;
  // Width of a count that can hold MAX_LEN itself
  localparam int CNT_W      = $clog2(MAX_LEN + 1);
  // Width of the reported length field
  localparam int LEN_W      = 11;

  // Word traveling down the cell chain
  typedef struct packed {
    logic                         tv;    // slot holds a word
    logic                         live;  // value still looking for its tail
    logic                         mark;  // last word of the sequence
    logic signed [DATA_WIDTH-1:0] key;   // the value itself
    logic [CNT_W-1:0]             len;   // valid cells counted by the marker
  } lis_tok_t;

endpackage

// File: rtl/lis_cell.sv
`timescale 1ns / 1ps

module lis_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  lis_pkg::lis_tok_t tok_i,
  output lis_pkg::lis_tok_t tok_o,
  output logic            valid_o
);
  import lis_pkg::*;

  logic signed [DATA_WIDTH-1:0] tail_q, tail_d;
  logic                         valid_q, valid_d;
  logic                         tv_q;
  lis_tok_t                     tok_q, tok_d;
  logic                         hit;
  logic                         vld_after;

  // Take the value here if the cell is empty or its tail is not smaller
  assign hit       = tok_i.tv && tok_i.live && (!valid_q || (tail_q >= tok_i.key));
  assign vld_after = valid_q | hit;

  always_comb begin
    tail_d     = hit ? tok_i.key : tail_q;
    // The marker clears the cell behind it for the next sequence
    valid_d    = (tok_i.tv && tok_i.mark) ? 1'b0 : vld_after;
    tok_d      = tok_i;
    tok_d.live = tok_i.live && !hit;
    if (tok_i.mark && vld_after) begin
      tok_d.len = CNT_W'(tok_i.len + 1'b1);
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tv_q    <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_d;
      tv_q    <= tok_d.tv;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tail_q <= tail_d;
      tok_q  <= tok_d;
    end
  end

  // Hand the word to the next cell with its reset slot flag
  always_comb begin
    tok_o    = tok_q;
    tok_o.tv = tv_q;
  end

  assign valid_o = valid_q;

endmodule

// File: rtl/longest_increasing_subsequence.sv
`timescale 1ns / 1ps

// Longest strictly increasing subsequence of a stream of signed 32-bit words.
// Send values on s_axis with tlast on the final value of a sequence; one result
// word (length and overflow) comes out on m_axis per sequence. The block takes
// one word every cycle while s_axis_tready is high. Each word walks a chain of
// MAX_LEN cells (one per tail entry), one cell per cycle; the result is registered
// as the marker leaves the last cell, and sequences may follow each other without
// gaps. While a result waits on m_axis the whole chain holds and s_axis_tready
// drops. Appends beyond MAX_LEN entries are dropped and flagged as overflow.
module longest_increasing_subsequence (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [10:0] lis_length, [11] overflow, [15:12] zero
);
  import lis_pkg::*;

  lis_tok_t             tok [MAX_LEN+1];
  logic [MAX_LEN-1:0]   cell_vld;
  logic                 en;
  lis_tok_t             tok_end;
  logic                 end_mark;
  logic                 end_drop;
  logic                 ovf_q, ovf_d;
  logic                 res_vld_q, res_vld_d;
  logic [LEN_W-1:0]     res_len_q;
  logic                 res_ovf_q;
  logic [CNT_W+LEN_W-1:0] len_ext;

  // Advance the chain unless a result is stuck at the output
  assign en            = !res_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Feed the accepted word into the first cell
  always_comb begin
    tok[0].tv   = s_axis_tvalid;
    tok[0].live = 1'b1;
    tok[0].mark = s_axis_tlast;
    tok[0].key  = s_axis_tdata[DATA_WIDTH-1:0];
    tok[0].len  = '0;
  end

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    lis_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1]),
      .valid_o(cell_vld[k])
    );
  end

  assign tok_end  = tok[MAX_LEN];
  assign end_mark = tok_end.tv && tok_end.mark;
  // A value still live past the last cell is a dropped append
  assign end_drop = tok_end.tv && tok_end.live;
  assign len_ext  = {{LEN_W{1'b0}}, tok_end.len};

  // Collect overflow and release the result when the marker leaves the chain
  always_comb begin
    ovf_d     = ovf_q;
    res_vld_d = res_vld_q;
    if (en) begin
      res_vld_d = end_mark;
      if (end_mark) begin
        ovf_d = 1'b0;
      end else if (end_drop) begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      ovf_q     <= ovf_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && end_mark) begin
      res_len_q <= len_ext[LEN_W-1:0];
      res_ovf_q <= ovf_q | end_drop;
    end
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {4'b0000, res_ovf_q, res_len_q};

`ifndef SYNTHESIS
  // A sequence holds at least one value
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (res_len_q != '0))
    else $error("result length is zero");

  // Reported length never exceeds the table capacity
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> ({{CNT_W{1'b0}}, res_len_q} <= (CNT_W + LEN_W)'(MAX_LEN)))
    else $error("result length beyond capacity");

  // Cell 1 is filled only if cell 0 is, except right behind a passing marker
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_vld[1] && !cell_vld[0]) |-> (tok[1].tv && tok[1].mark))
    else $error("tail table has a hole");
`endif

endmodule

// File: test/lis_checker.sv
`timescale 1ns / 1ps

module lis_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,   // [31:0] value
  input  logic        s_tlast_i,   // last
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,   // [10:0] lis_length, [11] overflow, [15:12] zero
  output int          errors_o,
  output int          pending_o
);
  import lis_pkg::*;

  typedef struct packed {
    logic [LEN_W-1:0] lis_length;
    logic             overflow;
  } lis_result_t;

  // Shadow tail table of the current sequence
  logic signed [DATA_WIDTH-1:0] tails [MAX_LEN];
  int unsigned                  tail_cnt;
  bit                           dropped;
  lis_result_t                  length_q [$];

  // Fold one value into the tail table: append past the end, else lower the first tail >= it
  function automatic void absorb_value(logic signed [DATA_WIDTH-1:0] v);
    int unsigned k;
    if (tail_cnt == 0 || v > tails[tail_cnt-1]) begin
      if (tail_cnt >= MAX_LEN) begin
        dropped = 1'b1;
      end else begin
        tails[tail_cnt] = v;
        tail_cnt++;
      end
    end else begin
      for (k = 0; k < tail_cnt; k++) begin
        if (tails[k] >= v) begin
          tails[k] = v;
          break;
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lis_result_t want;
    if (!rst_ni) begin
      tail_cnt = 0;
      dropped = 1'b0;
      length_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      // Predict on every accepted input word, close the sequence on tlast
      if (s_tvalid_i && s_tready_i) begin
        absorb_value(s_tdata_i);
        if (s_tlast_i) begin
          want.lis_length = tail_cnt[LEN_W-1:0];
          want.overflow = dropped;
          length_q = {length_q, want};
          tail_cnt = 0;
          dropped = 1'b0;
        end
      end
      // Compare each result word with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        if (length_q.size() == 0) begin
          $error("result word %h with no prediction waiting", m_tdata_i);
          errors_o++;
        end else begin
          want = length_q.pop_front();
          if (m_tdata_i[10:0] !== want.lis_length) begin
            $error("lis_length: expected %0d, actual %0d", want.lis_length, m_tdata_i[10:0]);
            errors_o++;
          end
          if (m_tdata_i[11] !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, m_tdata_i[11]);
            errors_o++;
          end
          if (m_tdata_i[15:12] !== 4'b0) begin
            $error("padding: expected 0, actual %h", m_tdata_i[15:12]);
            errors_o++;
          end
        end
      end
      pending_o = length_q.size();
    end
  end

endmodule

// File: test/tb_longest_increasing_subsequence.sv
`timescale 1ns / 1ps

module tb_longest_increasing_subsequence;
  import lis_pkg::*;

  localparam int RAND_ITEMS   = 1500;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = MAX_LEN + 100;

  typedef enum int {
    FILL_RANDOM,
    FILL_NARROW,
    FILL_RISING,
    FILL_EXTREME,
    FILL_FALLING
  } fill_e;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] value
  logic        s_axis_tlast;   // last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [10:0] lis_length, [11] overflow, [15:12] zero

  int    errors;
  int    pending;
  int    cycles = 0;
  word_t word_q [$];

  longest_increasing_subsequence dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lis_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Idle cycles before a word, with occasional stretches of back-to-back traffic
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic add_word(input logic [31:0] v, input logic l);
    word_t w;
    w.value = v;
    w.last = l;
    word_q = {word_q, w};
  endtask

  // Result side: stall each result word by a random number of cycles
  initial begin
    int sink_calm;
    int gap;
    sink_calm = 0;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = pick_gap(sink_calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
        while (!m_axis_tvalid) @(posedge clk_i);
        repeat (gap - 1) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Input side: build the stimulus, stream it, then drain and judge
  initial begin
    int          src_calm;
    int          gap;
    int          seq_len;
    int          i;
    int          n;
    bit          long_done;
    fill_e       mode;
    logic [31:0] v;
    logic [31:0] prev;

    src_calm = 0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-word sequences at zero and both extremes
    add_word(32'h0000_0000, 1'b1);
    add_word(32'h8000_0000, 1'b1);
    add_word(32'h7fff_ffff, 1'b1);
    // Minimum then maximum
    add_word(32'h8000_0000, 1'b0);
    add_word(32'h7fff_ffff, 1'b1);
    // Equal values only replace
    add_word(32'd5, 1'b0);
    add_word(32'd5, 1'b0);
    add_word(32'd5, 1'b1);
    // Replacement of the first tail
    add_word(32'd3, 1'b0);
    add_word(32'd1, 1'b0);
    add_word(32'd2, 1'b1);
    // Replacement in the middle of the table
    add_word(32'd10, 1'b0);
    add_word(32'd20, 1'b0);
    add_word(32'd30, 1'b0);
    add_word(32'd15, 1'b1);
    // Strictly falling across the sign boundary
    add_word(32'h7fff_ffff, 1'b0);
    add_word(32'h0000_0000, 1'b0);
    add_word(32'hffff_ffff, 1'b0);
    add_word(32'h8000_0000, 1'b1);
    // Rising across zero
    add_word(32'hffff_ffff, 1'b0);
    add_word(32'h0000_0000, 1'b0);
    add_word(32'h0000_0001, 1'b1);

    n = 0;
    long_done = 1'b0;
    while (n < RAND_ITEMS) begin
      if (!long_done && n >= RAND_ITEMS / 8) begin
        // Fill the table to capacity, then push appends past it mixed with replacements
        long_done = 1'b1;
        v = 32'h8000_0000 + $urandom_range(0, 1000);
        for (i = 0; i < MAX_LEN; i++) begin
          add_word(v, 1'b0);
          v = v + $urandom_range(1, 3_000_000);
        end
        for (i = 0; i < 10; i++) begin
          if ($urandom_range(0, 1) == 0) begin
            add_word(32'h7fff_ffff, i == 9);
          end else begin
            add_word($urandom, i == 9);
          end
        end
        n += MAX_LEN + 10;
      end else begin
        mode = fill_e'($urandom_range(0, 4));
        if ($urandom_range(0, 7) == 0) begin
          seq_len = $urandom_range(41, 200);
        end else begin
          seq_len = $urandom_range(1, 40);
        end
        // Keep the total near the planned item count
        if (seq_len > RAND_ITEMS - n) begin
          seq_len = RAND_ITEMS - n;
        end
        prev = $urandom;
        for (i = 0; i < seq_len; i++) begin
          case (mode)
            FILL_RANDOM: v = $urandom;
            FILL_NARROW: v = $urandom_range(0, 16) - 8;
            FILL_RISING: begin
              if ($urandom_range(0, 9) == 0) begin
                v = $urandom;
              end else begin
                v = prev + $urandom_range(0, 40) - 4;
              end
            end
            FILL_EXTREME: begin
              case ($urandom_range(0, 4))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = 32'h0000_0000;
                3:       v = 32'hffff_ffff;
                default: v = 32'h0000_0001;
              endcase
            end
            default: v = prev - $urandom_range(0, 40) + 4;
          endcase
          add_word(v, i == seq_len - 1);
          prev = v;
        end
        n += seq_len;
      end
    end

    // Stream every word, holding each until accepted
    foreach (word_q[j]) begin
      gap = pick_gap(src_calm);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= word_q[j].value;
      s_axis_tlast <= word_q[j].last;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    // Wait for every predicted length, then watch for stray words
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
